// ===== sv/obpt_pkg.sv =====
// Shared constants, types and codes for the order book price-time table.
`default_nettype none
package obpt_pkg;

    localparam int DEPTH      = 64;
    localparam int PRICE_BITS = 32;
    localparam int ID_W       = 64;
    localparam int QTY_W      = 31;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEAVES     = 1 << IDX_W;
    localparam int LEVELS     = IDX_W;
    localparam int LIVE_W     = $clog2(DEPTH + 1);
    localparam int WAIT_W     = $clog2(LEVELS + 1);

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NEG_QTY   = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUP_ID    = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_NO_MATCH  = 3'd5
    } status_t;

    typedef struct packed {
        logic                  valid;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_W-1:0]      qty;
        logic [ID_W-1:0]       id;
    } slot_t;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
    } query_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic                  valid;
        logic [PRICE_BITS-1:0] price;
        logic [IDX_W-1:0]      idx;
    } node_t;

    typedef struct packed {
        status_t          status;
        logic             match_found;
        logic [ID_W-1:0]  match_id;
        logic [31:0]      match_price;
        logic [QTY_W-1:0] match_quantity;
    } res_t;

endpackage
`default_nettype wire

// ===== sv/obpt_req_if.sv =====
// Request channel: one order book command per beat.
`default_nettype none
interface obpt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [63:0]        order_id;
    logic               side;
    logic [31:0]        price;
    logic signed [31:0] quantity;

    modport source (output valid, action, order_id, side, price, quantity, input ready);
    modport sink (input valid, action, order_id, side, price, quantity, output ready);
endinterface
`default_nettype wire

// ===== sv/obpt_rsp_if.sv =====
// Response channel: one result per beat.
`default_nettype none
interface obpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        match_found;
    logic [63:0] match_id;
    logic [31:0] match_price;
    logic [30:0] match_quantity;

    modport source (output valid, status, match_found, match_id, match_price,
                    match_quantity, input ready);
    modport sink (input valid, status, match_found, match_id, match_price,
                  match_quantity, output ready);
endinterface
`default_nettype wire

// ===== sv/obpt_cell.sv =====
// One book slot: holds an order, compares it against the query, shifts down on remove.
`default_nettype none
module obpt_cell
    import obpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  query_t    query,
    input  cell_ctl_t ctl,
    input  slot_t     load_data,
    input  slot_t     nbr,
    output slot_t     slot,
    output logic      id_hit,
    output logic      elig
);

    logic                  valid_reg;
    logic                  side_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_W-1:0]      qty_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  id_hit_reg;
    logic                  elig_reg;
    logic                  in_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nbr.valid;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            side_reg  <= nbr.side;
            price_reg <= nbr.price;
            qty_reg   <= nbr.qty;
            id_reg    <= nbr.id;
        end
        else if (ctl.load)
        begin
            side_reg  <= load_data.side;
            price_reg <= load_data.price;
            qty_reg   <= load_data.qty;
            id_reg    <= load_data.id;
        end
    end

    // buy query takes sells at or below the limit, sell query takes buys at or above it
    assign in_limit = query.side ? (price_reg >= query.price) : (price_reg <= query.price);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_hit_reg <= 1'b0;
            elig_reg   <= 1'b0;
        end
        else
        begin
            id_hit_reg <= valid_reg && (id_reg == query.id);
            elig_reg   <= valid_reg && (side_reg != query.side) && in_limit;
        end
    end

    assign slot   = '{valid: valid_reg, side: side_reg, price: price_reg,
                      qty: qty_reg, id: id_reg};
    assign id_hit = id_hit_reg;
    assign elig   = elig_reg;

endmodule
`default_nettype wire

// ===== sv/obpt_best.sv =====
// Registered reduction tree that picks the best eligible price, earliest slot on ties.
`default_nettype none
module obpt_best
    import obpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  min_mode,
    input  logic [DEPTH-1:0]      elig,
    input  logic [PRICE_BITS-1:0] price [DEPTH],
    output logic                  best_valid,
    output logic [IDX_W-1:0]      best_idx
);

    node_t leaf     [LEAVES];
    node_t node_reg [1:LEAVES-1];

    function automatic node_t pick(input node_t a, input node_t b, input logic lo);
        logic b_better;
        b_better = b.valid && (!a.valid || (lo ? (b.price < a.price) : (b.price > a.price)));
        return b_better ? b : a;
    endfunction

    for (genvar i = 0; i < LEAVES; i++)
    begin : g_leaf
        if (i < DEPTH)
        begin : g_real
            assign leaf[i] = '{valid: elig[i], price: price[i], idx: IDX_W'(i)};
        end
        else
        begin : g_pad
            assign leaf[i] = '{valid: 1'b0, price: '0, idx: IDX_W'(i)};
        end
    end

    for (genvar k = 1; k < LEAVES; k++)
    begin : g_node
        node_t lc;
        node_t rc;
        if (2 * k >= LEAVES)
        begin : g_from_leaf
            assign lc = leaf[2 * k - LEAVES];
            assign rc = leaf[2 * k + 1 - LEAVES];
        end
        else
        begin : g_from_node
            assign lc = node_reg[2 * k];
            assign rc = node_reg[2 * k + 1];
        end

        always_ff @(posedge clk)
        begin
            node_reg[k] <= pick(lc, rc, min_mode);
        end
    end

    assign best_valid = node_reg[1].valid;
    assign best_idx   = node_reg[1].idx;

endmodule
`default_nettype wire

// ===== sv/order_book_price_time_table_top.sv =====
// Top level of the order book price-time table: command sequencer and row of slot cells.
// A book of up to DEPTH resting orders kept in arrival order in a row of cells,
// each cell comparing its own order against the command in parallel. One command is
// in flight at a time. An add, a remove of an absent id or an unused action code passes
// through the compare and decide states to a ready result, a remove of a present id also
// through a shift state (locate the id, then shift every later cell down by one in a single step),
// and a best match query also through the wait for the registered best-price tree, one
// level per cycle. A new request beat is taken once the previous command has handed its
// result to the output register, even while that result waits; a result that finds the
// output register still full waits with it.
`default_nettype none
module order_book_price_time_table_top
    import obpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    obpt_req_if.sink   req,
    obpt_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_SHIFT,
        S_TREE,
        S_FIN
    } state_t;

    state_t                state_reg;
    logic [1:0]            act_reg;
    query_t                query_reg;
    logic [31:0]           qty_reg;
    logic [LIVE_W-1:0]     count_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [WAIT_W-1:0]     wait_reg;
    res_t                  pend_reg;
    res_t                  out_reg;
    logic                  out_valid_reg;

    slot_t                 slot_arr  [DEPTH];
    cell_ctl_t             ctl_arr   [DEPTH];
    logic [PRICE_BITS-1:0] price_arr [DEPTH];
    logic [DEPTH-1:0]      hit_vec;
    logic [DEPTH-1:0]      elig_vec;
    slot_t                 load_data;
    logic                  any_hit;
    logic                  add_ok;
    status_t               add_status;
    logic                  out_load;
    logic [IDX_W-1:0]      hit_pos;
    logic                  best_valid;
    logic [IDX_W-1:0]      best_idx;
    slot_t                 best_slot;

    assign load_data = '{valid: 1'b1, side: query_reg.side, price: query_reg.price,
                         qty: qty_reg[QTY_W-1:0], id: query_reg.id};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slot_t nbr;
        if (i + 1 < DEPTH)
        begin : g_mid
            assign nbr = slot_arr[i + 1];
        end
        else
        begin : g_end
            assign nbr = '0;
        end

        assign ctl_arr[i].load  = (state_reg == S_DEC) && (act_reg == ACT_ADD) && add_ok
                                  && (count_reg == LIVE_W'(i));
        assign ctl_arr[i].shift = (state_reg == S_SHIFT) && (pos_reg <= IDX_W'(i));
        assign price_arr[i]     = slot_arr[i].price;

        obpt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query_reg),
            .ctl       (ctl_arr[i]),
            .load_data (load_data),
            .nbr       (nbr),
            .slot      (slot_arr[i]),
            .id_hit    (hit_vec[i]),
            .elig      (elig_vec[i])
        );
    end

    obpt_best u_best (
        .clk        (clk),
        .min_mode   (~query_reg.side),
        .elig       (elig_vec),
        .price      (price_arr),
        .best_valid (best_valid),
        .best_idx   (best_idx)
    );

    assign any_hit   = |hit_vec;
    assign add_ok    = (add_status == ST_OK);
    assign best_slot = slot_arr[best_idx];
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        if (qty_reg[31])
        begin
            add_status = ST_NEG_QTY;
        end
        else if (count_reg == LIVE_W'(DEPTH))
        begin
            add_status = ST_FULL;
        end
        else if (any_hit)
        begin
            add_status = ST_DUP_ID;
        end
        else
        begin
            add_status = ST_OK;
        end
    end

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_vec[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_ADD;
            query_reg     <= '0;
            qty_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            wait_reg      <= '0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_reg       <= pend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg   <= req.action;
                        query_reg <= '{id: req.order_id, side: req.side,
                                       price: PRICE_BITS'(req.price)};
                        qty_reg   <= req.quantity;
                        state_reg <= S_CMP;
                    end
                end

                S_CMP:
                begin
                    state_reg <= S_DEC;
                end

                S_DEC:
                begin
                    case (act_reg)
                        ACT_ADD:
                        begin
                            pend_reg <= '{status: add_status, match_found: 1'b0,
                                          match_id: '0, match_price: '0,
                                          match_quantity: '0};
                            if (add_ok)
                            begin
                                count_reg <= count_reg + LIVE_W'(1);
                            end
                            state_reg <= S_FIN;
                        end
                        ACT_REMOVE:
                        begin
                            if (any_hit)
                            begin
                                pend_reg  <= '0;
                                pos_reg   <= hit_pos;
                                state_reg <= S_SHIFT;
                            end
                            else
                            begin
                                pend_reg  <= '{status: ST_NOT_FOUND, match_found: 1'b0,
                                               match_id: '0, match_price: '0,
                                               match_quantity: '0};
                                state_reg <= S_FIN;
                            end
                        end
                        ACT_QUERY:
                        begin
                            wait_reg  <= WAIT_W'(LEVELS - 1);
                            state_reg <= S_TREE;
                        end
                        default:
                        begin
                            pend_reg  <= '0;
                            state_reg <= S_FIN;
                        end
                    endcase
                end

                S_SHIFT:
                begin
                    count_reg <= count_reg - LIVE_W'(1);
                    state_reg <= S_FIN;
                end

                S_TREE:
                begin
                    if (wait_reg == '0)
                    begin
                        if (best_valid)
                        begin
                            pend_reg <= '{status: ST_OK, match_found: 1'b1,
                                          match_id: best_slot.id,
                                          match_price: 32'(best_slot.price),
                                          match_quantity: best_slot.qty};
                        end
                        else
                        begin
                            pend_reg <= '{status: ST_NO_MATCH, match_found: 1'b0,
                                          match_id: '0, match_price: '0,
                                          match_quantity: '0};
                        end
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - WAIT_W'(1);
                    end
                end

                S_FIN:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.match_found    = out_reg.match_found;
    assign rsp.match_id       = out_reg.match_id;
    assign rsp.match_price    = out_reg.match_price;
    assign rsp.match_quantity = out_reg.match_quantity;

endmodule
`default_nettype wire

// ===== sim/order_book_price_time_table_top_tb.sv =====
// Self-checking testbench for the order book price-time table: directed and random beats against a predictor.
module order_book_price_time_table_top_tb;
    import obpt_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1625;
    localparam int ID_POOL      = 96;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 500;
    localparam int DRAIN_AT     = 1100;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]         action;
        logic [63:0]        order_id;
        logic               side;
        logic [31:0]        price;
        logic signed [31:0] quantity;
    } book_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    obpt_req_if req();
    obpt_rsp_if rsp();

    order_book_price_time_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    book_cmd_t pending_beats[$];
    res_t      expected_results[$];

    logic [63:0]           book_id[DEPTH];
    logic                  book_side[DEPTH];
    logic [PRICE_BITS-1:0] book_price[DEPTH];
    logic [QTY_W-1:0]      book_qty[DEPTH];
    int                    book_count = 0;

    logic [63:0] id_pool[ID_POOL];

    int gap_left;
    int beats_taken;
    logic drain_hold;
    int stall_left;
    int results_seen;
    logic long_hold;
    int hold_cycles;
    logic hold_done;
    int mismatch_count = 0;
    int cycle_count = 0;

    function automatic int locate_id(logic [63:0] id);
        for (int i = 0; i < book_count; i++)
        begin
            if (book_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic res_t apply_command(book_cmd_t c);
        res_t r;
        int pos;
        int best;
        r = '0;
        r.status = ST_OK;
        case (c.action)
            ACT_ADD:
            begin
                if (c.quantity[31])
                    r.status = ST_NEG_QTY;
                else if (book_count >= DEPTH)
                    r.status = ST_FULL;
                else if (locate_id(c.order_id) >= 0)
                    r.status = ST_DUP_ID;
                else
                begin
                    book_id[book_count]    = c.order_id;
                    book_side[book_count]  = c.side;
                    book_price[book_count] = c.price[PRICE_BITS-1:0];
                    book_qty[book_count]   = c.quantity[QTY_W-1:0];
                    book_count++;
                end
            end
            ACT_REMOVE:
            begin
                pos = locate_id(c.order_id);
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = pos; i + 1 < book_count; i++)
                    begin
                        book_id[i]    = book_id[i + 1];
                        book_side[i]  = book_side[i + 1];
                        book_price[i] = book_price[i + 1];
                        book_qty[i]   = book_qty[i + 1];
                    end
                    book_count--;
                end
            end
            ACT_QUERY:
            begin
                best = -1;
                for (int i = 0; i < book_count; i++)
                begin
                    if (book_side[i] != c.side)
                    begin
                        if (!c.side)
                        begin
                            if (book_price[i] <= c.price[PRICE_BITS-1:0]
                                && (best < 0 || book_price[i] < book_price[best]))
                                best = i;
                        end
                        else
                        begin
                            if (book_price[i] >= c.price[PRICE_BITS-1:0]
                                && (best < 0 || book_price[i] > book_price[best]))
                                best = i;
                        end
                    end
                end
                if (best < 0)
                    r.status = ST_NO_MATCH;
                else
                begin
                    r.match_found    = 1'b1;
                    r.match_id       = book_id[best];
                    r.match_price    = book_price[best];
                    r.match_quantity = book_qty[best];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic book_cmd_t book_cmd(logic [1:0] action, logic [63:0] id, logic side,
                                           logic [31:0] price, logic signed [31:0] qty);
        book_cmd_t c;
        c.action   = action;
        c.order_id = id;
        c.side     = side;
        c.price    = price;
        c.quantity = qty;
        return c;
    endfunction

    function automatic logic [63:0] pick_id();
        if ($urandom_range(0, 99) < 88)
            return id_pool[$urandom_range(0, ID_POOL - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_price();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 32'd1000 + $urandom_range(0, 31);
        if (roll < 76)
            return 32'd0;
        if (roll < 82)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_qty();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return $urandom | 32'h8000_0000;
        if (roll < 14)
            return 32'sd0;
        if (roll < 18)
            return 32'sh7FFF_FFFF;
        return $urandom & 32'h7FFF_FFFF;
    endfunction

    task automatic queue_directed_traffic();
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b0, 32'hFFFF_FFFF, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b1, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_REMOVE, 64'd42, 1'b0, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd0, 1'b0, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_ADD, '1, 1'b1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF));
        pending_beats.push_back(book_cmd(ACT_ADD, '1, 1'b0, 32'd5, 32'sd1));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd3, 1'b0, 32'd5, 32'sh8000_0000));
        pending_beats.push_back(book_cmd(ACT_ADD, '1, 1'b0, 32'd5, -32'sd1));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd5, 1'b1, 32'd1000, 32'sd10));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd6, 1'b1, 32'd1000, 32'sd20));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd7, 1'b1, 32'd900, 32'sd30));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd8, 1'b0, 32'd1200, 32'sd40));
        pending_beats.push_back(book_cmd(ACT_ADD, 64'd9, 1'b0, 32'd1200, 32'sd50));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b0, 32'd1000, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b0, 32'd899, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b0, 32'hFFFF_FFFF, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b1, 32'd1200, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b1, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b1, 32'd1201, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_REMOVE, 64'd7, 1'b1, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b0, 32'd1000, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_REMOVE, 64'd8, 1'b0, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_UNUSED, '1, 1'b1, 32'hFFFF_FFFF, -32'sd1));
        pending_beats.push_back(book_cmd(ACT_REMOVE, 64'd0, 1'b0, 32'd0, 32'sd0));
        pending_beats.push_back(book_cmd(ACT_QUERY, 64'd0, 1'b1, 32'd0, 32'sd0));
    endtask

    task automatic queue_random_traffic();
        int seg_left;
        int mode;
        int roll;
        logic [1:0] act;
        seg_left = 0;
        mode = 3;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (seg_left == 0)
            begin
                mode = (mode + 1) % 4;
                seg_left = $urandom_range(40, 90);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            case (mode)
                0, 1:    act = (roll < 60) ? ACT_ADD : (roll < 70) ? ACT_REMOVE :
                               (roll < 95) ? ACT_QUERY : ACT_UNUSED;
                2:       act = (roll < 35) ? ACT_ADD : (roll < 65) ? ACT_REMOVE :
                               (roll < 95) ? ACT_QUERY : ACT_UNUSED;
                default: act = (roll < 15) ? ACT_ADD : (roll < 70) ? ACT_REMOVE :
                               (roll < 95) ? ACT_QUERY : ACT_UNUSED;
            endcase
            pending_beats.push_back(book_cmd(act, pick_id(), 1'($urandom_range(0, 1)),
                                             pick_price(), pick_qty()));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid    <= 1'b0;
            req.action   <= ACT_ADD;
            req.order_id <= '0;
            req.side     <= 1'b0;
            req.price    <= '0;
            req.quantity <= '0;
            gap_left     = 0;
            beats_taken  = 0;
            drain_hold   = 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_results.push_back(apply_command(pending_beats.pop_front()));
                beats_taken++;
                gap_left = ((beats_taken / 150) % 3 == 2) ? 0 : $urandom_range(0, 17);
                if (beats_taken == DRAIN_AT)
                    drain_hold = 1'b1;
            end
            if (drain_hold && expected_results.size() == 0)
                drain_hold = 1'b0;
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0 || drain_hold || pending_beats.size() == 0)
                begin
                    req.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    req.valid    <= 1'b1;
                    req.action   <= pending_beats[0].action;
                    req.order_id <= pending_beats[0].order_id;
                    req.side     <= pending_beats[0].side;
                    req.price    <= pending_beats[0].price;
                    req.quantity <= pending_beats[0].quantity;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold   <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (!hold_done && results_seen == HOLD_AT)
        begin
            long_hold   <= 1'b1;
            hold_done   <= 1'b1;
            hold_cycles <= HOLD_LEN;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                long_hold <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            rsp.ready    <= 1'b0;
            results_seen <= 0;
            stall_left   = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status         = status_t'(rsp.status);
                got.match_found    = rsp.match_found;
                got.match_id       = rsp.match_id;
                got.match_price    = rsp.match_price;
                got.match_quantity = rsp.match_quantity;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected beat %0d: status %0d found %0b id %h price %h qty %h",
                                 results_seen, got.status, got.match_found, got.match_id,
                                 got.match_price, got.match_quantity);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.match_found != want.match_found
                        || got.match_id != want.match_id || got.match_price != want.match_price
                        || got.match_quantity != want.match_quantity)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("mismatch at beat %0d", results_seen);
                            $display("  expected status %0d found %0b id %h price %h qty %h",
                                     want.status, want.match_found, want.match_id,
                                     want.match_price, want.match_quantity);
                            $display("  actual   status %0d found %0b id %h price %h qty %h",
                                     got.status, got.match_found, got.match_id,
                                     got.match_price, got.match_quantity);
                        end
                    end
                end
                results_seen <= results_seen + 1;
                stall_left = ((results_seen / 200) % 3 == 1) ? 0 : $urandom_range(0, 17);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= !long_hold;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        for (int j = 0; j < ID_POOL; j++)
            id_pool[j] = (j < 80) ? 64'(j) : {$urandom, $urandom};
        id_pool[80] = '1;
        id_pool[81] = 64'h8000_0000_0000_0000;
        queue_directed_traffic();
        queue_random_traffic();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_beats.size() != 0)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
